/* rtl/core/lpe_pkg.sv */
// Package for the LCD palette pixel expander: field widths, opcodes, depth codes,
// the palette port structs and the pixel slicing and RGB565 expansion functions.
// Depends on nothing; every other file of the block imports it.
package lpe_pkg;

  localparam int COLOR_W = 24;
  localparam int PIX_W   = 16;
  localparam int PWORD_W = 32;
  localparam int PIDX_W  = 8;
  localparam int MODE_W  = 3;
  localparam int K_W     = 4;

  typedef enum logic {
    OP_PAL_WRITE = 1'b0,
    OP_PIXELS    = 1'b1
  } opcode_t;

  localparam logic [MODE_W-1:0] DEPTH_1BPP  = 3'd0;
  localparam logic [MODE_W-1:0] DEPTH_2BPP  = 3'd1;
  localparam logic [MODE_W-1:0] DEPTH_4BPP  = 3'd2;
  localparam logic [MODE_W-1:0] DEPTH_8BPP  = 3'd3;
  localparam logic [MODE_W-1:0] DEPTH_16BPP = 3'd4;

  typedef struct packed {
    logic               en;
    logic [PIDX_W-1:0]  index;
    logic [COLOR_W-1:0] color;
  } pal_wr_t;

  typedef struct packed {
    logic              en;
    logic [PIDX_W-1:0] index;
  } pal_rd_t;

  // Index of the last pixel in a word for the given depth.
  function automatic logic [K_W-1:0] last_k(input logic [MODE_W-1:0] mode);
    case (mode)
      DEPTH_1BPP:  last_k = 4'd15;
      DEPTH_2BPP:  last_k = 4'd7;
      DEPTH_4BPP:  last_k = 4'd3;
      DEPTH_8BPP:  last_k = 4'd1;
      DEPTH_16BPP: last_k = 4'd0;
      default:     last_k = 4'd0;
    endcase
  endfunction

  // Direct color: 16 bpp and the unused codes above it.
  function automatic logic is_direct(input logic [MODE_W-1:0] mode);
    case (mode)
      DEPTH_1BPP, DEPTH_2BPP, DEPTH_4BPP, DEPTH_8BPP: is_direct = 1'b0;
      default: is_direct = 1'b1;
    endcase
  endfunction

  // Palette index of the pixel at the top of the (left-aligned) word.
  function automatic logic [PIDX_W-1:0] pixel_index(input logic [MODE_W-1:0] mode,
                                                    input logic [PIX_W-1:0]  w);
    case (mode)
      DEPTH_1BPP: pixel_index = {7'd0, w[15]};
      DEPTH_2BPP: pixel_index = {6'd0, w[15:14]};
      DEPTH_4BPP: pixel_index = {4'd0, w[15:12]};
      default:    pixel_index = w[15:8];
    endcase
  endfunction

  // Drop the pixel just taken and bring the next one to the top.
  function automatic logic [PIX_W-1:0] shift_word(input logic [MODE_W-1:0] mode,
                                                  input logic [PIX_W-1:0]  w);
    case (mode)
      DEPTH_1BPP: shift_word = {w[14:0], 1'b0};
      DEPTH_2BPP: shift_word = {w[13:0], 2'b0};
      DEPTH_4BPP: shift_word = {w[11:0], 4'b0};
      default:    shift_word = {w[7:0], 8'b0};
    endcase
  endfunction

  // RGB565 to 24 bits; each field is padded with its own low bits.
  function automatic logic [COLOR_W-1:0] expand_565(input logic [PIX_W-1:0] p);
    expand_565 = {p[4:0], p[2:0], p[10:5], p[6:5], p[15:11], p[13:11]};
  endfunction

endpackage

/* rtl/core/lpe_if.sv */
// Request channel interfaces of the LCD palette pixel expander: input items and pixels.
// Depends on lpe_pkg for the field widths.
interface lpe_in_if;
  import lpe_pkg::*;

  logic               valid;
  logic               ready;
  logic               opcode;
  logic [PIDX_W-1:0]  palette_index;
  logic [PWORD_W-1:0] palette_word;
  logic [PIX_W-1:0]   pixel_word;

  modport source (output valid, opcode, palette_index, palette_word, pixel_word,
                  input ready);
  modport sink   (input valid, opcode, palette_index, palette_word, pixel_word,
                  output ready);
endinterface

interface lpe_out_if;
  import lpe_pkg::*;

  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] pixel_color;
  logic               last_pixel;

  modport source (output valid, pixel_color, last_pixel, input ready);
  modport sink   (input valid, pixel_color, last_pixel, output ready);
endinterface

/* rtl/core/lpe_palette.sv */
// Palette store: one write port, one read port, registered read data.
// Depends on lpe_pkg for the port structs; entries never written read as zero.
module lpe_palette #(
  parameter int ENTRIES = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  lpe_pkg::pal_wr_t            wr,
  input  lpe_pkg::pal_rd_t            rd,
  output logic [lpe_pkg::COLOR_W-1:0] rd_color
);
  import lpe_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);

  logic [COLOR_W-1:0] mem [ENTRIES];
  logic [ENTRIES-1:0] written;
  logic [COLOR_W-1:0] rd_data;
  logic               rd_hit;
  logic               wr_ok;
  logic               rd_ok;
  logic [IDX_W-1:0]   wr_addr;
  logic [IDX_W-1:0]   rd_addr;

  assign wr_ok   = wr.en && ({1'b0, wr.index} < (PIDX_W + 1)'(ENTRIES));
  assign rd_ok   = {1'b0, rd.index} < (PIDX_W + 1)'(ENTRIES);
  assign wr_addr = wr.index[IDX_W-1:0];
  assign rd_addr = rd.index[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_addr] <= wr.color;
    end
    if (rd.en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_hit  <= 1'b0;
    end else begin
      if (wr_ok) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd.en) begin
        rd_hit <= rd_ok && written[rd_addr];
      end
    end
  end

  // Out-of-range or never-written entries read as black.
  assign rd_color = rd_hit ? rd_data : '0;

endmodule

/* rtl/core/lcd_palette_pixel_expander.sv */
// Top level of the LCD palette pixel expander: issue sequencer, palette lookup stage,
// two-entry output queue. Depends on lpe_pkg, lpe_if (lpe_in_if, lpe_out_if), lpe_palette.
//
//   channel   dir  payload                                            handshake
//   pix_in    in   opcode, palette_index, palette_word, pixel_word    valid/ready
//   pix_out   out  pixel_color, last_pixel                            valid/ready
//   cfg       in   cfg_wdata (depth_mode)                             cfg_we
//
// One pixel per clock unless pix_out stalls, set by the single read port of the palette
// store: a pixel word holds 16/bpp pixels (16, 8, 4, 2) at palette depths and one at
// 16 bpp. A pixel goes from the sequencer through the lookup stage into the output queue.
// Reset (rst, synchronous) clears the depth, the queues and the written flags of the
// palette directly; no clearing pass. A stall on pix_out holds the sequencer once
// the lookup stage and queue hold two pixels; pix_in keeps accepting up to then.
module lcd_palette_pixel_expander #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [lpe_pkg::MODE_W-1:0] cfg_wdata,
  lpe_in_if.sink                     pix_in,
  lpe_out_if.source                  pix_out
);
  import lpe_pkg::*;

  logic [MODE_W-1:0]  depth_mode;

  // Issue stage: the request being worked on.
  logic               busy;
  opcode_t            op;
  logic [PIX_W-1:0]   word;
  logic [PIDX_W-1:0]  wr_index;
  logic [COLOR_W-1:0] wr_color;
  logic [K_W-1:0]     pix_k;

  // Lookup stage: the palette read is in flight here.
  logic               s1_valid;
  logic               s1_last;
  logic               s1_direct;
  logic [COLOR_W-1:0] s1_color;

  // Output queue.
  logic [COLOR_W:0]   fifo_mem [2];
  logic               fifo_wr_ptr;
  logic               fifo_rd_ptr;
  logic [1:0]         fifo_count;

  logic [1:0]         occupancy;
  logic               pop;
  logic               can_issue;
  logic               issue;
  logic               is_last;
  logic               done;
  logic               in_acc;
  pal_wr_t            pal_wr;
  pal_rd_t            pal_rd;
  logic [COLOR_W-1:0] pal_color;
  logic [COLOR_W-1:0] pix_color_mux;

  // Pixels in the lookup stage plus the queue may not exceed its two slots after this
  // cycle's pop; that guarantees the lookup stage always drains.
  assign pop       = pix_out.valid && pix_out.ready;
  assign occupancy = {1'b0, s1_valid} + fifo_count - {1'b0, pop};
  assign can_issue = occupancy < 2'd2;
  assign issue     = busy && (op == OP_PIXELS) && can_issue;
  assign is_last   = pix_k == last_k(depth_mode);
  assign done      = busy && ((op == OP_PAL_WRITE) || (can_issue && is_last));

  // Take the next request in the cycle the current one finishes.
  assign pix_in.ready = !busy || done;
  assign in_acc       = pix_in.valid && pix_in.ready;

  // Writes and lookups go to the store in request order, one per cycle, so a lookup
  // always sees every earlier write and none of the later ones.
  assign pal_wr.en    = busy && (op == OP_PAL_WRITE);
  assign pal_wr.index = wr_index;
  assign pal_wr.color = wr_color;
  assign pal_rd.en    = issue && !is_direct(depth_mode);
  assign pal_rd.index = pixel_index(depth_mode, word);

  lpe_palette #(
    .ENTRIES (PALETTE_ENTRIES)
  ) u_palette (
    .clk      (clk),
    .rst      (rst),
    .wr       (pal_wr),
    .rd       (pal_rd),
    .rd_color (pal_color)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_mode <= DEPTH_1BPP;
    end else if (cfg_we) begin
      depth_mode <= cfg_wdata;
    end
  end

  // Sequencer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      pix_k <= '0;
    end else begin
      if (in_acc) begin
        busy  <= 1'b1;
        pix_k <= '0;
      end else begin
        if (done) begin
          busy <= 1'b0;
        end
        if (issue) begin
          pix_k <= pix_k + 1'b1;
        end
      end
    end
  end

  // Sequencer payload: latch the request, then shift the word one pixel per issue.
  // The palette color is byte0 high, byte3 middle, byte2 low.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op       <= opcode_t'(pix_in.opcode);
      word     <= pix_in.pixel_word;
      wr_index <= pix_in.palette_index;
      wr_color <= {pix_in.palette_word[7:0], pix_in.palette_word[31:24],
                   pix_in.palette_word[23:16]};
    end else if (issue) begin
      word <= shift_word(depth_mode, word);
    end
  end

  // Lookup stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_last   <= is_last;
      s1_direct <= is_direct(depth_mode);
      s1_color  <= expand_565(word);
    end
  end

  assign pix_color_mux = s1_direct ? s1_color : pal_color;

  // Output queue: push every pixel leaving the lookup stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_wr_ptr <= 1'b0;
      fifo_rd_ptr <= 1'b0;
      fifo_count  <= '0;
    end else begin
      if (s1_valid) begin
        fifo_wr_ptr <= ~fifo_wr_ptr;
      end
      if (pop) begin
        fifo_rd_ptr <= ~fifo_rd_ptr;
      end
      fifo_count <= fifo_count + {1'b0, s1_valid} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      fifo_mem[fifo_wr_ptr] <= {s1_last, pix_color_mux};
    end
  end

  assign pix_out.valid       = fifo_count != 2'd0;
  assign pix_out.last_pixel  = fifo_mem[fifo_rd_ptr][COLOR_W];
  assign pix_out.pixel_color = fifo_mem[fifo_rd_ptr][COLOR_W-1:0];

  // The lookup stage and the queue together never hold more than two pixels.
  a_occupancy_bound : assert property (@(posedge clk) disable iff (rst)
    ({1'b0, s1_valid} + fifo_count) <= 2'd2)
    else $error("lookup stage and output queue overfilled");

  // Writes and lookups never share a cycle at the store.
  a_one_store_access : assert property (@(posedge clk) disable iff (rst)
    !(pal_wr.en && pal_rd.en))
    else $error("palette write and lookup in the same cycle");

  // A stalled pixel word holds its position.
  a_stall_holds : assert property (@(posedge clk) disable iff (rst)
    (busy && (op == OP_PIXELS) && !can_issue) |=> ($stable(pix_k) && $stable(word)))
    else $error("sequencer advanced while stalled");

  // A palette write leaves the sequencer in the cycle after it, idle or holding the next request.
  a_write_one_cycle : assert property (@(posedge clk) disable iff (rst)
    (busy && (op == OP_PAL_WRITE)) |=> (!busy || $past(in_acc)))
    else $error("palette write held the sequencer");

endmodule
